// ===== rtl/core/jfml_pkg.sv =====
// Shared types, constants and register map for the JPEG frame marker locator
`timescale 1ns / 1ps

package jfml_pkg;

    localparam int MAX_FRAME_BYTES = 1048576;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int IDX_W           = (POS_W + 1 > 21) ? POS_W + 1 : 21;

    localparam int BYTE_W  = 8;
    localparam int HSL_W   = 16;
    localparam int LEN_W   = 21;
    localparam int OFF_W   = 20;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [OFF_W-1:0]  t_off;
    typedef logic [HSL_W-1:0]  t_hsl;

    localparam t_byte MARK_PREFIX = 8'hFF;
    localparam t_byte MARK_SOI    = 8'hD8;
    localparam t_byte MARK_EOI    = 8'hD9;

    localparam t_pos POS_LAST = t_pos'(MAX_FRAME_BYTES - 1);

    localparam t_hsl HSL_RESET    = 16'd10000;
    localparam t_len BUFLEN_RESET = 21'd1048576;
    localparam t_len BOUND_RESET  = 21'd1048574;

    localparam logic REG_HSL    = 1'b0;
    localparam logic REG_BUFLEN = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NO_HEAD   = 2'd1,
        ST_NO_TAIL   = 2'd2,
        ST_DUP_START = 2'd3
    } t_status;

    typedef struct packed {
        t_hsl head_search_limit;
        t_len tail_bound;
    } t_cfg;

    typedef struct packed {
        t_status status;
        t_off    start_offset;
        t_len    image_length;
    } t_result;

endpackage

// ===== rtl/core/jfml_in_if.sv =====
// Byte stream channel into the marker locator
`timescale 1ns / 1ps

interface jfml_in_if;
    logic                 valid;
    logic                 ready;
    jfml_pkg::t_byte      data_byte;
    logic                 first_of_frame;
    logic                 last_of_frame;
    jfml_pkg::t_off       tail_offset;

    modport source (output valid, data_byte, first_of_frame, last_of_frame, tail_offset,
                    input ready);
    modport sink   (input valid, data_byte, first_of_frame, last_of_frame, tail_offset,
                    output ready);
endinterface

// ===== rtl/core/jfml_out_if.sv =====
// Per-frame result channel out of the marker locator
`timescale 1ns / 1ps

interface jfml_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    jfml_pkg::t_off       start_offset;
    jfml_pkg::t_len       image_length;

    modport source (output valid, status, start_offset, image_length, input ready);
    modport sink   (input valid, status, start_offset, image_length, output ready);
endinterface

// ===== rtl/core/jfml_regs.sv =====
// APB configuration registers of the marker locator
`timescale 1ns / 1ps

module jfml_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfml_pkg::APB_AW-1:0]   paddr,
    input  logic [jfml_pkg::APB_DW-1:0]   pwdata,
    output logic [jfml_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output jfml_pkg::t_cfg                o_cfg
);

    jfml_pkg::t_hsl r_hsl;
    jfml_pkg::t_len r_buflen;
    jfml_pkg::t_len r_bound;
    jfml_pkg::t_len n_bound;
    jfml_pkg::t_len wr_len;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_len = pwdata[jfml_pkg::LEN_W-1:0];
    assign n_bound = (wr_len > jfml_pkg::t_len'(2)) ? wr_len - jfml_pkg::t_len'(2)
                                                     : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hsl    <= jfml_pkg::HSL_RESET;
            r_buflen <= jfml_pkg::BUFLEN_RESET;
            r_bound  <= jfml_pkg::BOUND_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                jfml_pkg::REG_HSL: begin
                    r_hsl <= pwdata[jfml_pkg::HSL_W-1:0];
                end
                jfml_pkg::REG_BUFLEN: begin
                    r_buflen <= wr_len;
                    r_bound  <= n_bound;
                end
                default: begin
                    r_hsl <= r_hsl;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            jfml_pkg::REG_HSL:    prdata = jfml_pkg::APB_DW'(r_hsl);
            jfml_pkg::REG_BUFLEN: prdata = jfml_pkg::APB_DW'(r_buflen);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.head_search_limit = r_hsl;
    assign o_cfg.tail_bound        = r_bound;

endmodule

// ===== rtl/core/jfml_scan.sv =====
// Per-byte marker search state and decision logic
`timescale 1ns / 1ps

module jfml_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  jfml_pkg::t_byte   i_data_byte,
    input  logic              i_first,
    input  logic              i_last,
    input  jfml_pkg::t_off    i_tail_offset,
    input  jfml_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output jfml_pkg::t_result o_res
);

    typedef enum logic {
        PH_HEAD,
        PH_TAIL
    } t_phase;

    jfml_pkg::t_byte r_prev_byte;
    jfml_pkg::t_pos  r_pos,     n_pos;
    t_phase          r_phase,   n_phase;
    jfml_pkg::t_pos  r_marker,  n_marker;
    jfml_pkg::t_off  r_skip,    n_skip;
    logic            r_decided, n_decided;
    jfml_pkg::t_idx  r_idx,     n_idx;

    jfml_pkg::t_pos  cur;
    jfml_pkg::t_idx  cur_w;
    jfml_pkg::t_idx  hsl_w;
    logic            is_ff;
    logic            is_soi;
    logic            is_eoi;
    logic            hit;
    jfml_pkg::t_result res;

    assign is_ff  = (r_prev_byte == jfml_pkg::MARK_PREFIX);
    assign is_soi = is_ff && (i_data_byte == jfml_pkg::MARK_SOI);
    assign is_eoi = is_ff && (i_data_byte == jfml_pkg::MARK_EOI);
    assign cur_w  = jfml_pkg::t_idx'(cur);
    assign hsl_w  = jfml_pkg::t_idx'(i_cfg.head_search_limit);

    always_comb begin
        cur       = i_first ? '0 : r_pos;
        n_phase   = i_first ? PH_HEAD : r_phase;
        n_marker  = i_first ? '0 : r_marker;
        n_skip    = i_first ? i_tail_offset : r_skip;
        n_decided = i_first ? 1'b0 : r_decided;
        n_idx     = r_idx;
        n_pos     = cur;
        hit       = 1'b0;
        res.status       = jfml_pkg::ST_FOUND;
        res.start_offset = '0;
        res.image_length = '0;

        if (!n_decided) begin
            if (cur != '0) begin
                if (n_phase == PH_HEAD) begin
                    if ((cur_w <= hsl_w) && is_soi) begin
                        n_marker = cur - jfml_pkg::t_pos'(1);
                        n_phase  = PH_TAIL;
                        n_idx    = jfml_pkg::t_idx'(1);
                    end else if (cur_w >= hsl_w) begin
                        hit        = 1'b1;
                        res.status = jfml_pkg::ST_NO_HEAD;
                    end
                end else begin
                    n_idx = r_idx + jfml_pkg::t_idx'(1);
                    if (r_idx >= jfml_pkg::t_idx'(i_cfg.tail_bound)) begin
                        hit              = 1'b1;
                        res.status       = jfml_pkg::ST_NO_TAIL;
                        res.start_offset = jfml_pkg::t_off'(n_marker);
                    end else if (r_idx >= jfml_pkg::t_idx'(n_skip)) begin
                        if (is_soi && (r_idx != '0)) begin
                            hit              = 1'b1;
                            res.status       = jfml_pkg::ST_DUP_START;
                            res.start_offset = jfml_pkg::t_off'(n_marker);
                        end else if (is_eoi) begin
                            hit              = 1'b1;
                            res.status       = jfml_pkg::ST_FOUND;
                            res.start_offset = jfml_pkg::t_off'(n_marker);
                            res.image_length =
                                jfml_pkg::t_len'(r_idx + jfml_pkg::t_idx'(2));
                        end
                    end
                end
            end
            if (!hit && (i_last || (cur >= jfml_pkg::POS_LAST))) begin
                hit = 1'b1;
                if (n_phase == PH_HEAD) begin
                    res.status = jfml_pkg::ST_NO_HEAD;
                end else begin
                    res.status       = jfml_pkg::ST_NO_TAIL;
                    res.start_offset = jfml_pkg::t_off'(n_marker);
                end
            end
            if (cur < jfml_pkg::POS_LAST) begin
                n_pos = cur + jfml_pkg::t_pos'(1);
            end
            n_decided = hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte <= '0;
            r_pos       <= '0;
            r_phase     <= PH_HEAD;
            r_marker    <= '0;
            r_skip      <= '0;
            r_decided   <= 1'b0;
            r_idx       <= '0;
        end else if (i_accept) begin
            r_prev_byte <= i_data_byte;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_marker    <= n_marker;
            r_skip      <= n_skip;
            r_decided   <= n_decided;
            r_idx       <= n_idx;
        end
    end

    assign o_res_valid = i_accept & hit;
    assign o_res       = res;

endmodule

// ===== rtl/core/jpeg_frame_marker_locator.sv =====
// Top level of the JPEG frame marker locator
`timescale 1ns / 1ps

// Usage
//   i_byte   : valid/ready byte stream of captured frames. first_of_frame opens a
//              frame and samples tail_offset; last_of_frame closes it.
//   o_result : valid/ready channel, at most one transaction per frame: status,
//              start_offset of the FF D8 marker and image_length through FF D9.
//   APB      : head search limit at 0x0, buffer length at 0x4. Write only while
//              the stream is idle; reads return the stored values.
// Timing
//   One byte per cycle when not stalled. A result shows on o_result the cycle after
//   the byte that decides it is taken; the decision is one pass of compare
//   logic on the byte, the previous byte and the offset counters.
//   Bytes that cause no result leave the output register alone.
// Reset
//   Synchronous, active low. Clears the search state, drops any pending
//   result and loads limit 10000 and buffer length 1048576.
// Back-pressure
//   With a result held and o_result.ready low, i_byte.ready falls; it rises
//   again in the cycle the held result is taken.
module jpeg_frame_marker_locator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jfml_in_if.sink                       i_byte,
    jfml_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfml_pkg::APB_AW-1:0]   paddr,
    input  logic [jfml_pkg::APB_DW-1:0]   pwdata,
    output logic [jfml_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    jfml_pkg::t_cfg    cfg;
    jfml_pkg::t_result scan_res;
    jfml_pkg::t_result r_res;
    logic              scan_valid;
    logic              r_out_valid;
    logic              in_ready;
    logic              accept;

    assign in_ready     = !r_out_valid || o_result.ready;
    assign accept       = i_byte.valid && in_ready;
    assign i_byte.ready = in_ready;

    jfml_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jfml_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_byte.data_byte),
        .i_first       (i_byte.first_of_frame),
        .i_last        (i_byte.last_of_frame),
        .i_tail_offset (i_byte.tail_offset),
        .i_cfg         (cfg),
        .o_res_valid   (scan_valid),
        .o_res         (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_valid) begin
            r_res <= scan_res;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_res.status;
    assign o_result.start_offset = r_res.start_offset;
    assign o_result.image_length = r_res.image_length;

endmodule

// ===== rtl/core/jfml_checker.sv =====
// Port-level assertions for the marker locator, bound to the top level
`timescale 1ns / 1ps

module jfml_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [1:0]             i_status,
    input jfml_pkg::t_off         i_start_offset,
    input jfml_pkg::t_len         i_image_length
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while result stalled");

    a_length_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != jfml_pkg::ST_FOUND)) |-> (i_image_length == '0))
        else $error("length on an error result");

    a_no_head_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == jfml_pkg::ST_NO_HEAD)) |-> (i_start_offset == '0))
        else $error("start offset without a start marker");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_start_offset) && $stable(i_image_length)))
        else $error("stalled result changed");

endmodule

bind jpeg_frame_marker_locator jfml_checker u_jfml_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_byte.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_status       (o_result.status),
    .i_start_offset (o_result.start_offset),
    .i_image_length (o_result.image_length)
);

// ===== sim/tb_jpeg_frame_marker_locator.sv =====
// Self-checking testbench for the JPEG frame marker locator
`timescale 1ns / 1ps

module tb_jpeg_frame_marker_locator;

    localparam int DIR_N         = 24;
    localparam int PHASE_BYTES   = 250;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int unsigned LAST_POS = jfml_pkg::MAX_FRAME_BYTES - 1;

    localparam logic [jfml_pkg::APB_AW-1:0] ADDR_HEAD_LIMIT = {jfml_pkg::REG_HSL, 2'b00};
    localparam logic [jfml_pkg::APB_AW-1:0] ADDR_BUF_LEN    = {jfml_pkg::REG_BUFLEN, 2'b00};

    typedef struct packed {
        jfml_pkg::t_byte data;
        logic            first;
        logic            last;
        jfml_pkg::t_off  toff;
    } t_item;

    typedef struct packed {
        t_item             it;
        logic              typed;
        jfml_pkg::t_result want;
    } t_row;

    localparam jfml_pkg::t_result NO_TYPED = '{jfml_pkg::ST_FOUND, 20'd0, 21'd0};

    localparam t_row DIR_ROWS [DIR_N] = '{
        '{'{8'h12, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD9, 1'b0, 1'b0, 20'd0}, 1'b1, '{jfml_pkg::ST_FOUND, 20'd1, 21'd4}},
        '{'{8'h00, 1'b0, 1'b1, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b1, 1'b1, 20'd0}, 1'b1, '{jfml_pkg::ST_NO_HEAD, 20'd0, 21'd0}},
        '{'{8'hFF, 1'b1, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b1, '{jfml_pkg::ST_DUP_START, 20'd0, 21'd0}},
        '{'{8'hFF, 1'b1, 1'b0, 20'd5}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD9, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hD9, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hFF, 1'b1, 1'b0, 20'hFFFFF}, 1'b0, NO_TYPED},
        '{'{8'hD8, 1'b0, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'h00, 1'b0, 1'b1, 20'd0}, 1'b1, '{jfml_pkg::ST_NO_TAIL, 20'd0, 21'd0}},
        '{'{8'hFF, 1'b1, 1'b0, 20'd0}, 1'b0, NO_TYPED},
        '{'{8'hAB, 1'b1, 1'b1, 20'd0}, 1'b1, '{jfml_pkg::ST_NO_HEAD, 20'd0, 21'd0}}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [jfml_pkg::APB_AW-1:0] paddr;
    logic [jfml_pkg::APB_DW-1:0] pwdata;
    logic [jfml_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    jfml_in_if  byte_ch ();
    jfml_out_if result_ch ();

    jpeg_frame_marker_locator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    jfml_pkg::t_hsl  cfg_head_limit;
    jfml_pkg::t_len  cfg_buf_len;
    jfml_pkg::t_byte prev_byte;
    int unsigned     scan_pos;
    logic            in_tail;
    int unsigned     mark_pos;
    jfml_pkg::t_off  skip_off;
    logic            decided;

    jfml_pkg::t_result pending_results [$];
    int      results_by_status [4];
    int      mismatches;
    int      live_bytes;
    int      sent_bytes;
    int      settings_used;
    int      quiet_cycles;
    logic    tx_idle;
    logic    rx_idle;
    logic    hold_req;

    task automatic locate_step(input t_item it, output logic has,
                               output jfml_pkg::t_result r);
        int unsigned cur;
        int unsigned q;
        int unsigned i;
        int unsigned bound;
        logic        ff;
        has = 1'b0;
        r   = NO_TYPED;
        if (it.first) begin
            scan_pos = 0;
            in_tail  = 1'b0;
            mark_pos = 0;
            skip_off = it.toff;
            decided  = 1'b0;
        end
        cur = scan_pos;
        if (!decided) begin
            live_bytes++;
            if (cur >= 1) begin
                q  = cur - 1;
                ff = (prev_byte == jfml_pkg::MARK_PREFIX);
                if (!in_tail) begin
                    if (q < cfg_head_limit && ff && it.data == jfml_pkg::MARK_SOI) begin
                        mark_pos = q;
                        in_tail  = 1'b1;
                    end else if (q + 1 >= cfg_head_limit) begin
                        has = 1'b1;
                        r   = '{jfml_pkg::ST_NO_HEAD, 20'd0, 21'd0};
                    end
                end else begin
                    i     = q - mark_pos;
                    bound = (cfg_buf_len > 2) ? cfg_buf_len - 2 : 0;
                    if (i >= bound) begin
                        has = 1'b1;
                        r   = '{jfml_pkg::ST_NO_TAIL, jfml_pkg::t_off'(mark_pos), 21'd0};
                    end else if (i >= skip_off) begin
                        if (ff && it.data == jfml_pkg::MARK_SOI && i != 0) begin
                            has = 1'b1;
                            r   = '{jfml_pkg::ST_DUP_START, jfml_pkg::t_off'(mark_pos),
                                    21'd0};
                        end else if (ff && it.data == jfml_pkg::MARK_EOI) begin
                            has = 1'b1;
                            r   = '{jfml_pkg::ST_FOUND, jfml_pkg::t_off'(mark_pos),
                                    jfml_pkg::t_len'(i + 2)};
                        end
                    end
                end
            end
            if (!has && (it.last || cur >= LAST_POS)) begin
                has = 1'b1;
                if (!in_tail)
                    r = '{jfml_pkg::ST_NO_HEAD, 20'd0, 21'd0};
                else
                    r = '{jfml_pkg::ST_NO_TAIL, jfml_pkg::t_off'(mark_pos), 21'd0};
            end
            if (has)
                decided = 1'b1;
            if (cur < LAST_POS)
                scan_pos = cur + 1;
        end
        prev_byte = it.data;
    endtask

    function automatic jfml_pkg::t_byte rand_byte(input int heat);
        jfml_pkg::t_byte b;
        if ($urandom_range(0, 99) < heat) begin
            case ($urandom_range(0, 2))
                0:       b = jfml_pkg::MARK_PREFIX;
                1:       b = jfml_pkg::MARK_SOI;
                default: b = jfml_pkg::MARK_EOI;
            endcase
        end else begin
            b = jfml_pkg::t_byte'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic t_item mk_item(input jfml_pkg::t_byte b);
        t_item it;
        it.data  = b;
        it.first = 1'b0;
        it.last  = 1'b0;
        it.toff  = jfml_pkg::t_off'($urandom_range(0, 20'hFFFFF));
        return it;
    endfunction

    task automatic send_byte(input t_item it, input logic typed,
                             input jfml_pkg::t_result want);
        int                gap;
        logic              has;
        jfml_pkg::t_result r;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        byte_ch.valid          <= 1'b1;
        byte_ch.data_byte      <= it.data;
        byte_ch.first_of_frame <= it.first;
        byte_ch.last_of_frame  <= it.last;
        byte_ch.tail_offset    <= it.toff;
        do @(posedge i_clk); while (!byte_ch.ready);
        sent_bytes++;
        locate_step(it, has, r);
        if (typed)
            pending_results.push_back(want);
        else if (has)
            pending_results.push_back(r);
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [jfml_pkg::APB_AW-1:0] addr,
                             input logic [jfml_pkg::APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read(input logic [jfml_pkg::APB_AW-1:0] addr,
                            output logic [jfml_pkg::APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_limits(input jfml_pkg::t_hsl limit, input jfml_pkg::t_len buf_len);
        logic [jfml_pkg::APB_DW-1:0] rd;
        reg_write(ADDR_HEAD_LIMIT, jfml_pkg::APB_DW'(limit));
        reg_write(ADDR_BUF_LEN, jfml_pkg::APB_DW'(buf_len));
        cfg_head_limit = limit;
        cfg_buf_len    = buf_len;
        settings_used++;
        reg_read(ADDR_HEAD_LIMIT, rd);
        if (rd !== jfml_pkg::APB_DW'(limit)) begin
            mismatches++;
            $display("%0t: head limit readback: expected %0d, got %0d", $time, limit, rd);
        end
        reg_read(ADDR_BUF_LEN, rd);
        if (rd !== jfml_pkg::APB_DW'(buf_len)) begin
            mismatches++;
            $display("%0t: buffer length readback: expected %0d, got %0d",
                     $time, buf_len, rd);
        end
    endtask

    task automatic random_frame();
        t_item          fr [$];
        int             kind;
        int             body;
        jfml_pkg::t_off toff;
        kind = $urandom_range(0, 9);
        body = $urandom_range(0, 24);
        case ($urandom_range(0, 19))
            0, 1, 2:       toff = jfml_pkg::t_off'($urandom_range(0, 20'hFFFFF));
            3, 4, 5, 6, 7: toff = jfml_pkg::t_off'($urandom_range(0, body + 4));
            default:       toff = jfml_pkg::t_off'($urandom_range(0, 4));
        endcase
        if (kind <= 6) begin
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6))
                fr.push_back(mk_item(rand_byte(20)));
            fr.push_back(mk_item(jfml_pkg::MARK_PREFIX));
            fr.push_back(mk_item(jfml_pkg::MARK_SOI));
            repeat (body) fr.push_back(mk_item(rand_byte(6)));
            if ($urandom_range(0, 4) != 0) begin
                fr.push_back(mk_item(jfml_pkg::MARK_PREFIX));
                fr.push_back(mk_item(jfml_pkg::MARK_EOI));
            end
            repeat ($urandom_range(0, 3)) fr.push_back(mk_item(rand_byte(20)));
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 30)) fr.push_back(mk_item(rand_byte(30)));
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 3)) fr.push_back(mk_item(rand_byte(50)));
        end else begin
            repeat ($urandom_range(1, 12)) fr.push_back(mk_item(rand_byte(20)));
        end
        if (kind != 9) begin
            fr[0].first = 1'b1;
            fr[0].toff  = toff;
        end
        foreach (fr[k])
            if ($urandom_range(0, (kind >= 7) ? 12 : 60) == 0)
                fr[k].last = 1'b1;
        if ($urandom_range(0, 9) != 0)
            fr[fr.size()-1].last = 1'b1;
        foreach (fr[k])
            send_byte(fr[k], 1'b0, NO_TYPED);
    endtask

    task automatic run_phase(input jfml_pkg::t_hsl limit, input jfml_pkg::t_len buf_len,
                             input logic hold);
        int start;
        quiesce();
        set_limits(limit, buf_len);
        hold_req = hold;
        start    = sent_bytes;
        while (sent_bytes - start < PHASE_BYTES) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            random_frame();
        end
    endtask

    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(negedge i_clk);
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = rx_idle ? $urandom_range(0, 6) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        jfml_pkg::t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_by_status[result_ch.status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: status %0d start %0d length %0d",
                         $time, result_ch.status, result_ch.start_offset,
                         result_ch.image_length);
            end else begin
                want = pending_results.pop_front();
                if (result_ch.status !== want.status
                        || result_ch.start_offset !== want.start_offset
                        || result_ch.image_length !== want.image_length) begin
                    mismatches++;
                    $display("%0t: expected status %0d start %0d length %0d, got %0d %0d %0d",
                             $time, want.status, want.start_offset, want.image_length,
                             result_ch.status, result_ch.start_offset,
                             result_ch.image_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_jpeg_frame_marker_locator: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        byte_ch.valid          = 1'b0;
        byte_ch.data_byte      = '0;
        byte_ch.first_of_frame = 1'b0;
        byte_ch.last_of_frame  = 1'b0;
        byte_ch.tail_offset    = '0;
        result_ch.ready        = 1'b0;
        tx_idle                = 1'b1;
        rx_idle                = 1'b1;
        hold_req               = 1'b0;
        quiet_cycles           = 0;
        mismatches             = 0;
        live_bytes             = 0;
        sent_bytes             = 0;
        settings_used          = 0;
        results_by_status      = '{0, 0, 0, 0};
        cfg_head_limit         = jfml_pkg::HSL_RESET;
        cfg_buf_len            = jfml_pkg::BUFLEN_RESET;
        prev_byte              = '0;
        scan_pos               = 0;
        in_tail                = 1'b0;
        mark_pos               = 0;
        skip_off               = '0;
        decided                = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++)
            send_byte(DIR_ROWS[k].it, DIR_ROWS[k].typed, DIR_ROWS[k].want);

        run_phase(16'd1, 21'd3, 1'b0);
        run_phase(16'd65535, jfml_pkg::BUFLEN_RESET, 1'b1);
        run_phase(16'd12, 21'd40, 1'b0);
        run_phase(16'd30, 21'd7, 1'b0);
        run_phase(jfml_pkg::t_hsl'($urandom_range(1, 64)),
                  jfml_pkg::t_len'($urandom_range(3, 90)), 1'b0);
        quiesce();

        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("covered: %0d bytes sent, %0d of them searched, over %0d register settings",
                 sent_bytes, live_bytes, settings_used);
        $display("results: found %0d, no start %0d, no end %0d, repeated start %0d",
                 results_by_status[jfml_pkg::ST_FOUND], results_by_status[jfml_pkg::ST_NO_HEAD],
                 results_by_status[jfml_pkg::ST_NO_TAIL],
                 results_by_status[jfml_pkg::ST_DUP_START]);
        if (mismatches == 0)
            $display("tb_jpeg_frame_marker_locator: done, clean");
        else
            $display("tb_jpeg_frame_marker_locator: done, errors");
        $finish;
    end

endmodule
